// ===== rtl/core/quaternion_multiply_rotate_defines.svh =====
// Assertion macros used by the quaternion multiply/rotate checker.
`ifndef QUATERNION_MULTIPLY_ROTATE_DEFINES_SVH
`define QUATERNION_MULTIPLY_ROTATE_DEFINES_SVH

// The consequent must hold at the same clock edge as the antecedent.
`define QMR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold at the clock edge after the antecedent.
`define QMR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/qmr_pkg.sv =====
// Types, constants and helper functions for the quaternion multiply/rotate block.
`timescale 1ns / 1ps

package qmr_pkg;

    // Component format and intermediate widths.
    localparam int QW   = 32;
    localparam int FRAC = 16;
    localparam int M1W  = 2 * QW - FRAC;
    localparam int M2W  = 2 * QW + 1 - FRAC;
    localparam int S1W  = M1W + 2;
    localparam int S2W  = M2W + 2;
    localparam int NTERM = 16;

    typedef logic signed [QW-1:0] t_comp;
    typedef logic signed [QW:0]   t_comp_ext;
    typedef logic [1:0]           t_sel;

    typedef enum logic {
        OP_PRODUCT = 1'b0,
        OP_ROTATE  = 1'b1
    } t_op;

    typedef struct packed {
        t_comp value;
        logic  ovf;
    } t_sat;

    // Hamilton product terms, four per result component in x, y, z, w order.
    // Term k multiplies p[P_IDX[k]] by q[Q_IDX[k]] and is subtracted where NEG[k] is set.
    localparam t_sel P_IDX [NTERM] = '{
        2'd3, 2'd0, 2'd1, 2'd2,
        2'd3, 2'd1, 2'd2, 2'd0,
        2'd3, 2'd2, 2'd0, 2'd1,
        2'd3, 2'd0, 2'd1, 2'd2
    };
    localparam t_sel Q_IDX [NTERM] = '{
        2'd0, 2'd3, 2'd2, 2'd1,
        2'd1, 2'd3, 2'd0, 2'd2,
        2'd2, 2'd3, 2'd1, 2'd0,
        2'd3, 2'd0, 2'd1, 2'd2
    };
    localparam logic NEG [NTERM] = '{
        1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b1, 1'b1, 1'b1
    };

    // Clamp a wide sum to the signed component range and flag any clamping.
    function automatic t_sat sat_comp(input logic signed [S2W-1:0] v);
        t_sat             res;
        logic [S2W-QW:0]  hi;
        hi = v[S2W-1:QW-1];
        if (hi == '0 || hi == '1) begin
            res.value = v[QW-1:0];
            res.ovf   = 1'b0;
        end else if (v[S2W-1]) begin
            res.value = {1'b1, {(QW-1){1'b0}}};
            res.ovf   = 1'b1;
        end else begin
            res.value = {1'b0, {(QW-1){1'b1}}};
            res.ovf   = 1'b1;
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/qmr_if.sv =====
// Valid/ready channel interfaces for operand items and result items.
`timescale 1ns / 1ps

interface qmr_in_if;
    logic                valid;
    logic                ready;
    logic                opcode;
    logic signed [31:0]  a_x;
    logic signed [31:0]  a_y;
    logic signed [31:0]  a_z;
    logic signed [31:0]  a_w;
    logic signed [31:0]  b_x;
    logic signed [31:0]  b_y;
    logic signed [31:0]  b_z;
    logic signed [31:0]  b_w;

    modport source (
        output valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
        input  ready
    );
    modport sink (
        input  valid, opcode, a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w,
        output ready
    );
endinterface

interface qmr_out_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  r_x;
    logic signed [31:0]  r_y;
    logic signed [31:0]  r_z;
    logic signed [31:0]  r_w;
    logic                overflow;

    modport source (
        output valid, r_x, r_y, r_z, r_w, overflow,
        input  ready
    );
    modport sink (
        input  valid, r_x, r_y, r_z, r_w, overflow,
        output ready
    );
endinterface

// ===== rtl/core/quaternion_multiply_rotate.sv =====
// Pipelined Q16.16 quaternion Hamilton product and rotation of b by a.
// Stages in order: operand, products, sums, saturation, products, sums, output.
// One item per cycle unless the output stalls; 16 multipliers in each multiply stage.
// A stalled output holds the pipeline only as far back as the first empty stage.
// Reset (synchronous, active low) empties every stage; no result is pending after it.
`timescale 1ns / 1ps

module quaternion_multiply_rotate (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qmr_in_if.sink     i_in,
    qmr_out_if.source  o_out
);
    import qmr_pkg::*;

    localparam int NST = 7;

    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    // Stage 0: operand register.
    logic  r_s0_op;
    t_comp r_s0_a [4];
    t_comp r_s0_b [4];
    // Stage 1: first set of products.
    logic                    r_s1_op;
    t_comp                   r_s1_a [4];
    logic signed [M1W-1:0]   r_s1_m [NTERM];
    // Stage 2: first set of sums.
    logic                    r_s2_op;
    t_comp                   r_s2_a [4];
    logic signed [S1W-1:0]   r_s2_s [4];
    // Stage 3: saturated intermediate and conjugate of a.
    logic                    r_s3_op;
    t_comp_ext               r_s3_ac [4];
    t_comp                   r_s3_t [4];
    logic                    r_s3_ovf;
    // Stage 4: second set of products.
    logic                    r_s4_op;
    t_comp                   r_s4_t [4];
    logic                    r_s4_ovf;
    logic signed [M2W-1:0]   r_s4_m [NTERM];
    // Stage 5: second set of sums.
    logic                    r_s5_op;
    t_comp                   r_s5_t [4];
    logic                    r_s5_ovf;
    logic signed [S2W-1:0]   r_s5_s [4];
    // Stage 6: output register.
    t_comp                   r_s6_r [4];
    logic                    r_s6_ovf;

    logic signed [2*QW-1:0]  p1_full [NTERM];
    logic signed [2*QW:0]    p2_full [NTERM];
    logic signed [M1W-1:0]   n_s1_m [NTERM];
    logic signed [S1W-1:0]   n_s2_s [4];
    t_comp                   n_s3_t [4];
    logic                    n_s3_ovf;
    t_comp_ext               n_s3_ac [4];
    logic signed [M2W-1:0]   n_s4_m [NTERM];
    logic signed [S2W-1:0]   n_s5_s [4];
    t_comp                   n_s6_r [4];
    logic                    n_s6_ovf;
    t_comp                   in_a [4];
    t_comp                   in_b [4];

    assign in_a[0] = i_in.a_x;
    assign in_a[1] = i_in.a_y;
    assign in_a[2] = i_in.a_z;
    assign in_a[3] = i_in.a_w;
    assign in_b[0] = i_in.b_x;
    assign in_b[1] = i_in.b_y;
    assign in_b[2] = i_in.b_z;
    assign in_b[3] = i_in.b_w;

    // A stage may load when it is empty or when the stage after it moves on.
    always_comb begin
        en[NST-1] = !r_v[NST-1] || o_out.ready;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    // First products a*b, floored back to Q16.16.
    always_comb begin
        for (int k = 0; k < NTERM; k++) begin
            p1_full[k] = r_s0_a[P_IDX[k]] * r_s0_b[Q_IDX[k]];
            n_s1_m[k]  = p1_full[k][2*QW-1:FRAC];
        end
    end

    // First sums, four terms per component.
    always_comb begin
        logic signed [S1W-1:0] acc;
        for (int c = 0; c < 4; c++) begin
            acc = '0;
            for (int j = 0; j < 4; j++) begin
                if (NEG[4*c+j]) begin
                    acc = acc - S1W'(r_s1_m[4*c+j]);
                end else begin
                    acc = acc + S1W'(r_s1_m[4*c+j]);
                end
            end
            n_s2_s[c] = acc;
        end
    end

    // Saturate the intermediate and form conj(a) one bit wider.
    always_comb begin
        t_sat sat;
        n_s3_ovf = 1'b0;
        for (int c = 0; c < 4; c++) begin
            sat       = sat_comp(S2W'(r_s2_s[c]));
            n_s3_t[c] = sat.value;
            n_s3_ovf  = n_s3_ovf | sat.ovf;
        end
        for (int c = 0; c < 3; c++) begin
            n_s3_ac[c] = -t_comp_ext'(r_s2_a[c]);
        end
        n_s3_ac[3] = t_comp_ext'(r_s2_a[3]);
    end

    // Second products t*conj(a), floored back to Q16.16.
    always_comb begin
        for (int k = 0; k < NTERM; k++) begin
            p2_full[k] = r_s3_t[P_IDX[k]] * r_s3_ac[Q_IDX[k]];
            n_s4_m[k]  = p2_full[k][2*QW:FRAC];
        end
    end

    // Second sums.
    always_comb begin
        logic signed [S2W-1:0] acc;
        for (int c = 0; c < 4; c++) begin
            acc = '0;
            for (int j = 0; j < 4; j++) begin
                if (NEG[4*c+j]) begin
                    acc = acc - S2W'(r_s4_m[4*c+j]);
                end else begin
                    acc = acc + S2W'(r_s4_m[4*c+j]);
                end
            end
            n_s5_s[c] = acc;
        end
    end

    // Final saturation and choice between product and rotation.
    always_comb begin
        t_sat sat;
        n_s6_ovf = r_s5_ovf;
        for (int c = 0; c < 4; c++) begin
            sat = sat_comp(r_s5_s[c]);
            if (r_s5_op == OP_ROTATE) begin
                n_s6_r[c] = sat.value;
                n_s6_ovf  = n_s6_ovf | sat.ovf;
            end else begin
                n_s6_r[c] = r_s5_t[c];
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0_op <= i_in.opcode;
            r_s0_a  <= in_a;
            r_s0_b  <= in_b;
        end
        if (en[1]) begin
            r_s1_op <= r_s0_op;
            r_s1_a  <= r_s0_a;
            r_s1_m  <= n_s1_m;
        end
        if (en[2]) begin
            r_s2_op <= r_s1_op;
            r_s2_a  <= r_s1_a;
            r_s2_s  <= n_s2_s;
        end
        if (en[3]) begin
            r_s3_op  <= r_s2_op;
            r_s3_ac  <= n_s3_ac;
            r_s3_t   <= n_s3_t;
            r_s3_ovf <= n_s3_ovf;
        end
        if (en[4]) begin
            r_s4_op  <= r_s3_op;
            r_s4_t   <= r_s3_t;
            r_s4_ovf <= r_s3_ovf;
            r_s4_m   <= n_s4_m;
        end
        if (en[5]) begin
            r_s5_op  <= r_s4_op;
            r_s5_t   <= r_s4_t;
            r_s5_ovf <= r_s4_ovf;
            r_s5_s   <= n_s5_s;
        end
        if (en[6]) begin
            r_s6_r   <= n_s6_r;
            r_s6_ovf <= n_s6_ovf;
        end
    end

    // Channel outputs.
    assign i_in.ready     = en[0];
    assign o_out.valid    = r_v[NST-1];
    assign o_out.r_x      = r_s6_r[0];
    assign o_out.r_y      = r_s6_r[1];
    assign o_out.r_z      = r_s6_r[2];
    assign o_out.r_w      = r_s6_r[3];
    assign o_out.overflow = r_s6_ovf;

endmodule

// ===== rtl/core/qmr_checker.sv =====
// Port-level checker for the quaternion multiply/rotate block, with its bind.
`timescale 1ns / 1ps
`include "quaternion_multiply_rotate_defines.svh"

module qmr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] i_r_x,
    input logic signed [31:0] i_r_y,
    input logic signed [31:0] i_r_z,
    input logic signed [31:0] i_r_w,
    input logic               i_overflow
);

    // The cycle after reset no result is offered.
    `QMR_ASSERT_SAME(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !i_out_valid, "result offered straight after reset")

    // With the result side free, the whole pipeline moves and takes a new item.
    `QMR_ASSERT_SAME(a_ready_chain, i_clk, i_rst_n, i_out_ready, i_in_ready, "input stalled while output side is free")

    // A stalled result stays offered.
    `QMR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result withdrawn before transfer")

    // A stalled result keeps its value.
    `QMR_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_r_x) && $stable(i_r_y) && $stable(i_r_z) && $stable(i_r_w) && $stable(i_overflow), "stalled result changed")

endmodule

bind quaternion_multiply_rotate qmr_checker u_qmr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_r_x       (o_out.r_x),
    .i_r_y       (o_out.r_y),
    .i_r_z       (o_out.r_z),
    .i_r_w       (o_out.r_w),
    .i_overflow  (o_out.overflow)
);

// ===== tb/sv/tb_quaternion_multiply_rotate.sv =====
// Self-checking testbench for the Q16.16 quaternion product and rotation block.
`timescale 1ns / 1ps

module tb_quaternion_multiply_rotate;
    import qmr_pkg::*;

    localparam int    ITEMS_PER_PHASE = 160;
    localparam int    QUIET_LIMIT     = 2000;
    localparam int    DRAIN_CYCLES    = 20;
    localparam int    MAX_REPORTS     = 10;
    localparam t_comp COMP_MAX        = 32'sh7fff_ffff;
    localparam t_comp COMP_MIN        = 32'sh8000_0000;
    localparam t_comp Q_ONE           = 32'sd65536;
    localparam t_comp COS_45          = 32'sd46341;
    localparam longint SUM_MAX        = 64'sd2147483647;
    localparam longint SUM_MIN        = -64'sd2147483648;

    // Sender idle and receiver stall percentages for each phase.
    localparam int PHASE_IDLE [4]  = '{0, 78, 0, 35};
    localparam int PHASE_STALL [4] = '{0, 0, 78, 35};

    typedef struct packed {
        t_op   op;
        t_comp a_x, a_y, a_z, a_w;
        t_comp b_x, b_y, b_z, b_w;
    } t_quat_req;

    typedef struct packed {
        t_comp r_x, r_y, r_z, r_w;
        logic  overflow;
    } t_quat_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    qmr_in_if  in_bus ();
    qmr_out_if out_bus ();

    quaternion_multiply_rotate DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_quat_req pending_reqs [$];
    t_quat_res expected_results [$];
    t_quat_req held_req;
    int        src_idle_pct   = 0;
    int        sink_stall_pct = 0;
    int        queued_count   = 0;
    int        accepted_count = 0;
    int        result_count   = 0;
    int        failures       = 0;
    int        quiet_cycles   = 0;

    always #5 i_clk = ~i_clk;

    // Product of two Q16.16 values, floored back to Q16.16.
    function automatic longint mul_floor(longint p, longint q);
        return (p * q) >>> 16;
    endfunction

    // Hamilton product p*q with each component clamped to 32 bits.
    function automatic void hamilton_sat(input longint p [4], input longint q [4],
                                         output longint r [4], inout bit ovf);
        longint sum [4];
        sum[0] = mul_floor(p[3], q[0]) + mul_floor(q[3], p[0])
               + mul_floor(p[1], q[2]) - mul_floor(p[2], q[1]);
        sum[1] = mul_floor(p[3], q[1]) + mul_floor(q[3], p[1])
               + mul_floor(p[2], q[0]) - mul_floor(p[0], q[2]);
        sum[2] = mul_floor(p[3], q[2]) + mul_floor(q[3], p[2])
               + mul_floor(p[0], q[1]) - mul_floor(p[1], q[0]);
        sum[3] = mul_floor(p[3], q[3]) - mul_floor(p[0], q[0])
               - mul_floor(p[1], q[1]) - mul_floor(p[2], q[2]);
        for (int i = 0; i < 4; i++) begin
            if (sum[i] > SUM_MAX) begin
                r[i] = SUM_MAX;
                ovf  = 1'b1;
            end else if (sum[i] < SUM_MIN) begin
                r[i] = SUM_MIN;
                ovf  = 1'b1;
            end else begin
                r[i] = sum[i];
            end
        end
    endfunction

    // Expected result of one operand item; the conjugate is taken in full 64-bit width.
    function automatic t_quat_res predict_quat(t_quat_req req);
        longint    a [4];
        longint    b [4];
        longint    t [4];
        longint    ac [4];
        longint    r [4];
        bit        ovf;
        t_quat_res res;
        ovf = 1'b0;
        a[0] = req.a_x; a[1] = req.a_y; a[2] = req.a_z; a[3] = req.a_w;
        b[0] = req.b_x; b[1] = req.b_y; b[2] = req.b_z; b[3] = req.b_w;
        hamilton_sat(a, b, t, ovf);
        if (req.op == OP_ROTATE) begin
            ac[0] = -a[0]; ac[1] = -a[1]; ac[2] = -a[2]; ac[3] = a[3];
            hamilton_sat(t, ac, r, ovf);
        end else begin
            r = t;
        end
        res.r_x      = r[0][31:0];
        res.r_y      = r[1][31:0];
        res.r_z      = r[2][31:0];
        res.r_w      = r[3][31:0];
        res.overflow = ovf;
        return res;
    endfunction

    // Mostly moderate magnitudes, with some full-range and boundary values.
    function automatic t_comp rand_comp();
        case ($urandom_range(0, 9))
            0: return t_comp'($urandom);
            1: begin
                case ($urandom_range(0, 5))
                    0: return COMP_MAX;
                    1: return COMP_MIN;
                    2: return '0;
                    3: return -32'sd1;
                    4: return Q_ONE;
                    default: return -Q_ONE;
                endcase
            end
            default: return t_comp'($signed($urandom) >>> $urandom_range(8, 30));
        endcase
    endfunction

    task automatic push_item(t_op op, t_comp ax, t_comp ay, t_comp az, t_comp aw,
                             t_comp bx, t_comp by, t_comp bz, t_comp bw);
        pending_reqs.push_back('{op, ax, ay, az, aw, bx, by, bz, bw});
        queued_count++;
    endtask

    // Random item; a rotation uses a unit quaternion half of the time.
    task automatic push_random();
        t_op   op;
        t_comp a [4];
        real   v [4];
        real   norm;
        op = t_op'($urandom_range(0, 1));
        for (int i = 0; i < 4; i++) a[i] = rand_comp();
        if (op == OP_ROTATE && $urandom_range(0, 1) == 1) begin
            norm = 0.0;
            for (int i = 0; i < 4; i++) begin
                v[i] = ($urandom_range(0, 2000) - 1000.0) / 1000.0;
                norm = norm + v[i] * v[i];
            end
            norm = $sqrt(norm);
            for (int i = 0; i < 4; i++) begin
                a[i] = (norm < 0.001) ? ((i == 3) ? Q_ONE : t_comp'(0))
                                      : t_comp'($rtoi(v[i] / norm * 65535.0));
            end
        end
        push_item(op, a[0], a[1], a[2], a[3], rand_comp(), rand_comp(), rand_comp(),
                  rand_comp());
    endtask

    task automatic report_error(string msg);
        failures++;
        if (failures <= MAX_REPORTS) $display("ERROR: %s", msg);
    endtask

    // Driver: offers queued items and records the expectation of each transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                expected_results.push_back(predict_quat(held_req));
                accepted_count++;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    held_req = pending_reqs.pop_front();
                    in_bus.opcode <= held_req.op;
                    in_bus.a_x    <= held_req.a_x;
                    in_bus.a_y    <= held_req.a_y;
                    in_bus.a_z    <= held_req.a_z;
                    in_bus.a_w    <= held_req.a_w;
                    in_bus.b_x    <= held_req.b_x;
                    in_bus.b_y    <= held_req.b_y;
                    in_bus.b_z    <= held_req.b_z;
                    in_bus.b_w    <= held_req.b_w;
                    in_bus.valid  <= 1'b1;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and a field-by-field check of each result transfer.
    always @(posedge i_clk) begin : result_monitor
        t_quat_res got;
        t_quat_res want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            out_bus.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            if (out_bus.valid && out_bus.ready) begin
                got = {out_bus.r_x, out_bus.r_y, out_bus.r_z, out_bus.r_w,
                       out_bus.overflow};
                if (expected_results.size() == 0) begin
                    report_error($sformatf("result %0d arrived with none expected",
                                           result_count));
                end else begin
                    want = expected_results.pop_front();
                    if (got.r_x !== want.r_x)
                        report_error($sformatf("result %0d r_x: expected %0d, got %0d",
                                               result_count, want.r_x, got.r_x));
                    if (got.r_y !== want.r_y)
                        report_error($sformatf("result %0d r_y: expected %0d, got %0d",
                                               result_count, want.r_y, got.r_y));
                    if (got.r_z !== want.r_z)
                        report_error($sformatf("result %0d r_z: expected %0d, got %0d",
                                               result_count, want.r_z, got.r_z));
                    if (got.r_w !== want.r_w)
                        report_error($sformatf("result %0d r_w: expected %0d, got %0d",
                                               result_count, want.r_w, got.r_w));
                    if (got.overflow !== want.overflow)
                        report_error($sformatf("result %0d overflow: expected %0b, got %0b",
                                               result_count, want.overflow, got.overflow));
                end
                result_count++;
            end
        end
    end

    // Count cycles without any transfer on either side.
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("quaternion_multiply_rotate test failed");
        $finish;
    end

    // Stimulus, phase by phase; each phase drains completely before the next.
    initial begin
        i_rst_n        = 1'b0;
        in_bus.valid   = 1'b0;
        in_bus.opcode  = 1'b0;
        in_bus.a_x     = '0;
        in_bus.a_y     = '0;
        in_bus.a_z     = '0;
        in_bus.a_w     = '0;
        in_bus.b_x     = '0;
        in_bus.b_y     = '0;
        in_bus.b_z     = '0;
        in_bus.b_w     = '0;
        out_bus.ready  = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = PHASE_IDLE[ph];
            sink_stall_pct = PHASE_STALL[ph];
            if (ph == 0) begin
                // Products: identity, zeros, the basis relation i*j = k and the extremes.
                push_item(OP_PRODUCT, 0, 0, 0, Q_ONE, Q_ONE, -Q_ONE, 2 * Q_ONE, 3 * Q_ONE);
                push_item(OP_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0);
                push_item(OP_PRODUCT, Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 0);
                push_item(OP_PRODUCT, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
                          COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
                push_item(OP_PRODUCT, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
                          COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
                push_item(OP_PRODUCT, COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN,
                          COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX);
                // Tiny negative products must round towards minus infinity.
                push_item(OP_PRODUCT, -1, -1, -1, -1, 1, 1, 1, 1);
                // Rotations: identity and a quarter turn about z.
                push_item(OP_ROTATE, 0, 0, 0, Q_ONE, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, 0);
                push_item(OP_ROTATE, 0, 0, COS_45, COS_45, Q_ONE, 0, 0, 0);
                // Conjugating the most negative x must not saturate.
                push_item(OP_ROTATE, COMP_MIN, 0, 0, 0, 0, 0, 0, 1);
                // The intermediate product saturates before the second product is formed.
                push_item(OP_ROTATE, 0, 0, 0, COMP_MAX, COMP_MAX, 0, 0, 0);
                push_item(OP_ROTATE, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX,
                          COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX);
                push_item(OP_ROTATE, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN,
                          COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN);
                push_item(OP_ROTATE, 0, 0, 0, 0, 0, 0, 0, 0);
                push_item(OP_ROTATE, -Q_ONE, 0, 0, 0, -1, -1, -1, -1);
            end
            repeat (ITEMS_PER_PHASE) push_random();
            // The sender stays paused until every outstanding result has arrived.
            while (accepted_count != queued_count || expected_results.size() != 0)
                @(posedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("quaternion_multiply_rotate test passed");
        end else begin
            $display("quaternion_multiply_rotate test failed");
        end
        $finish;
    end

endmodule
